/* hdl/aer_pkg.sv */
// ----------------------------------------------------------------------------
// aer_pkg: shared definitions for the ANSI escape rewriter
// Character codes, the queued job format, the held prefix table and the
// queue sizing used by the front, the queue and the back end.
// ----------------------------------------------------------------------------
package aer_pkg;

   // Character codes recognized by the parser.
   localparam logic [7:0] CH_ESC = 8'h1B;
   localparam logic [7:0] CH_LBR = 8'h5B;
   localparam logic [7:0] CH_S   = 8'h73;
   localparam logic [7:0] CH_U   = 8'h75;
   localparam logic [7:0] CH_QM  = 8'h3F;
   localparam logic [7:0] CH_7   = 8'h37;
   localparam logic [7:0] CH_8   = 8'h38;
   localparam logic [7:0] CH_2   = 8'h32;
   localparam logic [7:0] CH_0   = 8'h30;
   localparam logic [7:0] CH_6   = 8'h36;
   localparam logic [7:0] CH_H   = 8'h68;
   localparam logic [7:0] CH_L   = 8'h6C;

   // Queue between the parser and the serializer.
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   // One output burst: the first plen bytes of the held prefix, then last_byte.
   typedef struct packed {
      logic [2:0] plen;
      logic [7:0] last_byte;
   } job_type;

   // Queue status seen by both ends.
   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   // Bytes held back while a sequence is being matched, in arrival order.
   function automatic logic [7:0] prefix_byte(input logic [2:0] idx);
      logic [7:0] b;
      case (idx)
         3'd0:    b = CH_ESC;
         3'd1:    b = CH_LBR;
         3'd2:    b = CH_QM;
         3'd3:    b = CH_2;
         3'd4:    b = CH_0;
         3'd5:    b = CH_2;
         3'd6:    b = CH_6;
         default: b = 8'h00;
      endcase
      return b;
   endfunction

   // Byte that extends the synchronized-output prefix from a given stage.
   function automatic logic [7:0] next_match(input logic [2:0] stage);
      logic [7:0] b;
      case (stage)
         3'd3:    b = CH_2;
         3'd4:    b = CH_0;
         3'd5:    b = CH_2;
         3'd6:    b = CH_6;
         default: b = 8'h00;
      endcase
      return b;
   endfunction

endpackage

/* hdl/aer_front.sv */
// ----------------------------------------------------------------------------
// aer_front: escape sequence parser
// Tracks how far an escape sequence has matched and turns each accepted
// byte into at most one output job for the back end.
// ----------------------------------------------------------------------------
module aer_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             accept,
   input  logic [7:0]       in_byte,
   output logic             job_valid,
   output aer_pkg::job_type job
);
   import aer_pkg::*;

   // Parser stages, each named after the bytes already held back.
   localparam logic [2:0] ST_NORMAL = 3'd0;
   localparam logic [2:0] ST_ESC    = 3'd1;
   localparam logic [2:0] ST_CSI    = 3'd2;
   localparam logic [2:0] ST_QM     = 3'd3;
   localparam logic [2:0] ST_Q2     = 3'd4;
   localparam logic [2:0] ST_Q20    = 3'd5;
   localparam logic [2:0] ST_Q202   = 3'd6;
   localparam logic [2:0] ST_Q2026  = 3'd7;

   logic [2:0] stage_ff;
   logic [2:0] stage_in;
   logic [2:0] next_stage;

   // Classify the current byte against the current stage.
   always_comb begin
      next_stage    = ST_NORMAL;
      job_valid     = 1'b0;
      job.plen      = 3'd0;
      job.last_byte = in_byte;
      unique case (stage_ff)
         ST_NORMAL: begin
            if (in_byte == CH_ESC) begin
               next_stage = ST_ESC;
            end else begin
               job_valid = 1'b1;
            end
         end
         ST_ESC: begin
            if (in_byte == CH_LBR) begin
               next_stage = ST_CSI;
            end else if (in_byte == CH_ESC) begin
               // The first ESC goes out alone; the second one is held again.
               job_valid  = 1'b1;
               next_stage = ST_ESC;
            end else begin
               job_valid = 1'b1;
               job.plen  = 3'd1;
            end
         end
         ST_CSI: begin
            if (in_byte == CH_S) begin
               job_valid     = 1'b1;
               job.plen      = 3'd1;
               job.last_byte = CH_7;
            end else if (in_byte == CH_U) begin
               job_valid     = 1'b1;
               job.plen      = 3'd1;
               job.last_byte = CH_8;
            end else if (in_byte == CH_QM) begin
               next_stage = ST_QM;
            end else begin
               job_valid = 1'b1;
               job.plen  = stage_ff;
            end
         end
         ST_QM, ST_Q2, ST_Q20, ST_Q202: begin
            if (in_byte == next_match(stage_ff)) begin
               next_stage = stage_ff + 3'd1;
            end else begin
               job_valid = 1'b1;
               job.plen  = stage_ff;
            end
         end
         ST_Q2026: begin
            // The synchronized-output switch is dropped entirely.
            if (in_byte != CH_H && in_byte != CH_L) begin
               job_valid = 1'b1;
               job.plen  = stage_ff;
            end
         end
         default: begin
            next_stage = ST_NORMAL;
         end
      endcase
   end

   // The stage only moves on an accepted transaction.
   assign stage_in = accept ? next_stage : stage_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff <= ST_NORMAL;
      end else begin
         stage_ff <= stage_in;
      end
   end

endmodule

/* hdl/aer_queue.sv */
// ----------------------------------------------------------------------------
// aer_queue: job queue
// A short first-in first-out store that lets the parser and the serializer
// stall independently of each other.
// ----------------------------------------------------------------------------
module aer_queue (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  aer_pkg::job_type          push_job,
   input  logic                      pop,
   output aer_pkg::job_type          head_job,
   output aer_pkg::queue_status_type status
);
   import aer_pkg::*;

   job_type                  entry_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0]   wr_ptr_ff;
   logic [QUEUE_PTR_W-1:0]   wr_ptr_in;
   logic [QUEUE_PTR_W-1:0]   rd_ptr_ff;
   logic [QUEUE_PTR_W-1:0]   rd_ptr_in;
   logic [QUEUE_CNT_W-1:0]   count_ff;
   logic [QUEUE_CNT_W-1:0]   count_in;
   logic                     do_push;
   logic                     do_pop;

   assign status.full  = (count_ff == QUEUE_CNT_W'(QUEUE_DEPTH));
   assign status.empty = (count_ff == '0);
   assign do_push      = push && !status.full;
   assign do_pop       = pop && !status.empty;
   assign head_job     = entry_ff[rd_ptr_ff];

   // Pointer and occupancy update.
   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage needs no reset.
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

/* hdl/aer_back.sv */
// ----------------------------------------------------------------------------
// aer_back: output serializer
// Walks the job at the head of the queue into the result register one byte
// per cycle while the result is not stalled, and retires the job with its last byte.
// ----------------------------------------------------------------------------
module aer_back (
   input  logic                      clock,
   input  logic                      reset,
   input  aer_pkg::job_type          head_job,
   input  aer_pkg::queue_status_type status,
   output logic                      pop,
   input  logic                      rsp_stall,
   output logic                      rsp_valid,
   output logic [7:0]                rsp_out_byte,
   output logic                      rsp_is_last
);
   import aer_pkg::*;

   logic [2:0] idx_ff;
   logic [2:0] idx_in;
   logic       valid_ff;
   logic       valid_in;
   logic [7:0] byte_ff;
   logic [7:0] byte_in;
   logic       last_ff;
   logic       last_in;
   logic       load;
   logic       at_end;

   // The result register takes a new byte when empty or when its transaction completes.
   assign load   = !valid_ff || !rsp_stall;
   assign at_end = (idx_ff == head_job.plen);
   assign pop    = load && !status.empty && at_end;

   always_comb begin
      idx_in   = idx_ff;
      valid_in = valid_ff;
      byte_in  = byte_ff;
      last_in  = last_ff;
      if (load) begin
         valid_in = !status.empty;
         if (!status.empty) begin
            byte_in = at_end ? head_job.last_byte : prefix_byte(idx_ff);
            last_in = at_end;
            idx_in  = at_end ? 3'd0 : idx_ff + 3'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= 3'd0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
      last_ff <= last_in;
   end

   assign rsp_valid    = valid_ff;
   assign rsp_out_byte = byte_ff;
   assign rsp_is_last  = last_ff;

`ifndef SYNTHESIS
   // The byte index never runs past the prefix length of the job being sent.
   a_idx_in_range: assert property (@(posedge clock) disable iff (reset)
      !status.empty |-> (idx_ff <= head_job.plen))
      else $error("serializer index beyond job length");

   // With no job waiting the serializer sits at the start of a burst.
   a_idx_idle: assert property (@(posedge clock) disable iff (reset)
      status.empty |-> (idx_ff == 3'd0))
      else $error("serializer index not cleared while queue is empty");

   // A stalled result freezes the walk through the current job.
   a_stall_holds_idx: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && rsp_stall) |=> (idx_ff == $past(idx_ff)))
      else $error("serializer advanced while the result was stalled");

   // A job is retired only together with its flagged final byte.
   a_pop_with_last: assert property (@(posedge clock) disable iff (reset)
      pop |=> (valid_ff && last_ff))
      else $error("job retired without a final byte");
`endif

endmodule

/* hdl/ansi_escape_rewriter_top.sv */
// ----------------------------------------------------------------------------
// ansi_escape_rewriter_top: terminal escape sequence rewriter
// Rewrites save/restore cursor sequences, drops the synchronized-output
// switch and passes everything else through unchanged.
// ----------------------------------------------------------------------------
// Usage:
//   The req_ channel carries one terminal byte per transaction; a transaction
//   completes at a rising edge with req_valid high and req_stall low.
//   The rsp_ channel delivers zero to eight bytes per input byte in order;
//   rsp_is_last flags the final byte caused by one input byte.
//   Bytes that may start a recognized sequence are held back and produce no
//   output until the sequence is resolved.
//   The first output byte of an input transaction is written to the job queue
//   and then to the output register before it is presented.
//   Throughput: one input byte per cycle while each produces at most one
//   output byte and no stall holds the flow; a replay burst goes out through
//   the single-byte-per-cycle serializer.
//   A four-entry job queue sits between parser and serializer; req_stall
//   rises only when that queue is full.
//   When rsp_stall is high the current output byte holds and the queue fills.
//   Synchronous reset returns the parser to normal text and empties the queue
//   and the output register.
// ----------------------------------------------------------------------------
module ansi_escape_rewriter_top (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_in_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_is_last
);
   import aer_pkg::*;

   logic             req_accept;
   logic             job_valid;
   job_type          front_job;
   job_type          head_job;
   queue_status_type status;
   logic             pop;

   // Input transactions are refused only when the queue has no room.
   assign req_stall  = status.full;
   assign req_accept = req_valid && !req_stall;

   aer_front u_front (
      .clock     (clock),
      .reset     (reset),
      .accept    (req_accept),
      .in_byte   (req_in_byte),
      .job_valid (job_valid),
      .job       (front_job)
   );

   aer_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (req_accept && job_valid),
      .push_job (front_job),
      .pop      (pop),
      .head_job (head_job),
      .status   (status)
   );

   aer_back u_back (
      .clock        (clock),
      .reset        (reset),
      .head_job     (head_job),
      .status       (status),
      .pop          (pop),
      .rsp_stall    (rsp_stall),
      .rsp_valid    (rsp_valid),
      .rsp_out_byte (rsp_out_byte),
      .rsp_is_last  (rsp_is_last)
   );

endmodule

/* sim/rewriter_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rewriter_checker: output predictor and comparator for the escape rewriter
// Watches both channels of the rewriter. Every accepted input byte runs
// through a local copy of the escape-sequence parser, which queues the
// output bytes it should produce. Every accepted output byte is compared
// with the oldest queued byte and its last-of-burst flag.
// ----------------------------------------------------------------------------
module rewriter_checker (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_stall,
   input  logic [7:0] req_in_byte,
   input  logic       rsp_valid,
   input  logic       rsp_stall,
   input  logic [7:0] rsp_out_byte,
   input  logic       rsp_is_last,
   output int         mismatch_count,
   output int         outstanding
);
   import aer_pkg::*;

   // How far the parser has matched a sequence.
   typedef enum logic [2:0] {
      ST_TEXT, ST_ESC, ST_CSI, ST_QM, ST_Q2, ST_Q20, ST_Q202, ST_Q2026
   } parse_stage_type;

   typedef struct packed {
      logic [7:0] data;
      logic       is_last;
   } out_beat_type;

   // Bytes held back on the way to the synchronized-output switch.
   localparam logic [7:0] SYNC_PREFIX [7] = '{CH_ESC, CH_LBR, CH_QM, CH_2, CH_0, CH_2, CH_6};

   parse_stage_type stage;
   out_beat_type    expected_beats[$];
   out_beat_type    want_beat;
   int              beat_index;

   // Counts a failure and reports only the first few of them.
   task automatic flag_error(input string what);
      mismatch_count++;
      if (mismatch_count <= 10) begin
         $display("[%0t] output byte %0d: %s", $realtime, beat_index, what);
      end
   endtask

   // Advances the parser by one byte and queues the bytes it releases.
   task automatic predict_byte(input logic [7:0] c);
      logic [7:0] burst[$];
      int         replay_len;
      replay_len = -1;
      case (stage)
         ST_TEXT: begin
            if (c == CH_ESC) stage = ST_ESC;
            else burst.push_back(c);
         end
         ST_ESC: begin
            if (c == CH_LBR) begin
               stage = ST_CSI;
            end else begin
               // A lone ESC goes out; a second ESC may start a new sequence.
               burst.push_back(CH_ESC);
               if (c == CH_ESC) begin
                  stage = ST_ESC;
               end else begin
                  burst.push_back(c);
                  stage = ST_TEXT;
               end
            end
         end
         ST_CSI: begin
            if (c == CH_S) begin
               burst = '{CH_ESC, CH_7};
               stage = ST_TEXT;
            end else if (c == CH_U) begin
               burst = '{CH_ESC, CH_8};
               stage = ST_TEXT;
            end else if (c == CH_QM) begin
               stage = ST_QM;
            end else begin
               replay_len = 2;
            end
         end
         ST_Q2026: begin
            // h or l completes the switch, which is swallowed.
            if (c != CH_H && c != CH_L) replay_len = 7;
            stage = ST_TEXT;
         end
         default: begin
            if (c == SYNC_PREFIX[int'(stage)]) stage = parse_stage_type'(int'(stage) + 1);
            else replay_len = int'(stage);
         end
      endcase

      // A broken sequence replays everything held, then the byte itself.
      if (replay_len >= 0) begin
         for (int k = 0; k < replay_len; k++) burst.push_back(SYNC_PREFIX[k]);
         burst.push_back(c);
         stage = ST_TEXT;
      end

      foreach (burst[i]) begin
         expected_beats.push_back('{data: burst[i], is_last: (i == burst.size() - 1)});
      end
   endtask

   // Compare outputs first, then predict from the input taken at the same edge.
   always @(posedge clock) begin
      if (reset) begin
         stage = ST_TEXT;
         expected_beats.delete();
         mismatch_count = 0;
         beat_index = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_beats.size() == 0) begin
               flag_error($sformatf("unexpected byte %02h last %0b", rsp_out_byte, rsp_is_last));
            end else begin
               want_beat = expected_beats.pop_front();
               if (rsp_out_byte !== want_beat.data || rsp_is_last !== want_beat.is_last) begin
                  flag_error($sformatf("expected %02h last %0b, got %02h last %0b",
                                       want_beat.data, want_beat.is_last,
                                       rsp_out_byte, rsp_is_last));
               end
            end
            beat_index++;
         end
         if (req_valid && !req_stall) predict_byte(req_in_byte);
      end
      outstanding = expected_beats.size();
   end

endmodule

/* sim/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: stimulus and verdict for the ANSI escape rewriter
// Feeds a directed set of escape sequences and then a long random stream of
// whole, broken and lone sequences mixed with plain text, with random gaps
// on the input and random stalls on the output. A separate checker predicts
// and compares every output byte.
// ----------------------------------------------------------------------------
module testbench;
   import aer_pkg::*;

   localparam int LIMIT_CYCLES = 1000000;
   localparam int STREAM_LEN   = 480;

   // Extremes, both rewrites, both swallowed switches and a lone ESC pair.
   localparam logic [7:0] OPENING [27] = '{
      8'h00, 8'hFF,
      CH_ESC, CH_LBR, CH_S,
      CH_ESC, CH_LBR, CH_U,
      CH_ESC, CH_LBR, CH_QM, CH_2, CH_0, CH_2, CH_6, CH_H,
      CH_ESC, CH_ESC, 8'h41,
      CH_ESC, CH_LBR, CH_QM, CH_2, CH_0, CH_2, CH_6, CH_L
   };

   localparam logic [7:0] SYNC_PREFIX [7] = '{CH_ESC, CH_LBR, CH_QM, CH_2, CH_0, CH_2, CH_6};

   // Characters that steer the parser, drawn often so that sequences collide.
   localparam logic [7:0] KEY_CHARS [10] = '{
      CH_ESC, CH_LBR, CH_QM, CH_2, CH_0, CH_6, CH_H, CH_L, CH_S, CH_U
   };

   logic       clock;
   logic       reset       = 1'b1;
   logic       req_valid   = 1'b0;
   logic       req_stall;
   logic [7:0] req_in_byte = 8'h00;
   logic       rsp_valid;
   logic       rsp_stall   = 1'b0;
   logic [7:0] rsp_out_byte;
   logic       rsp_is_last;

   int         mismatches;
   int         outstanding;
   logic [7:0] stream[$];

   ansi_escape_rewriter_top dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_in_byte (req_in_byte),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_out_byte(rsp_out_byte),
      .rsp_is_last (rsp_is_last)
   );

   rewriter_checker rewrite_check (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_in_byte   (req_in_byte),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_out_byte  (rsp_out_byte),
      .rsp_is_last   (rsp_is_last),
      .mismatch_count(mismatches),
      .outstanding   (outstanding)
   );

   // Mostly no gap, often a short one, now and then a long one.
   function automatic int idle_cycles(input bit calm);
      int r;
      if (calm) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   function automatic logic [7:0] rand_byte();
      if ($urandom_range(0, 2) == 0) return KEY_CHARS[$urandom_range(0, 9)];
      return 8'($urandom_range(0, 255));
   endfunction

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Watchdog against a hung handshake.
   initial begin
      repeat (LIMIT_CYCLES) @(posedge clock);
      $display("== FAIL ==");
      $finish;
   end

   // Output stalls, with calm stretches and one long hold-off that fills the
   // block until it stalls its input.
   initial begin
      int hold;
      int free_cycles;
      int elapsed;
      bit calm;
      bit pressure_done;
      elapsed = 0;
      calm = 1'b0;
      pressure_done = 1'b0;
      wait (!reset);
      @(negedge clock);
      forever begin
         if (!pressure_done && elapsed >= 300) begin
            pressure_done = 1'b1;
            hold = 120;
         end else begin
            if ($urandom_range(0, 15) == 0) calm = !calm;
            hold = idle_cycles(calm);
         end
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(negedge clock);
         end
         rsp_stall <= 1'b0;
         free_cycles = $urandom_range(1, 6);
         repeat (free_cycles) @(negedge clock);
         elapsed += hold + free_cycles;
      end
   end

   // Builds the byte stream, sends it and gives the verdict.
   initial begin
      int gap;
      int depth;

      foreach (OPENING[i]) stream.push_back(OPENING[i]);

      // Random part: whole sequences with random neighbors, broken and lone ones.
      while (stream.size() < STREAM_LEN) begin
         case ($urandom_range(0, 9))
            0, 1, 2, 3: stream.push_back(rand_byte());
            4: begin
               stream.push_back(CH_ESC);
               stream.push_back(CH_LBR);
               stream.push_back($urandom_range(0, 1) ? CH_S : CH_U);
            end
            5, 6: begin
               foreach (SYNC_PREFIX[k]) stream.push_back(SYNC_PREFIX[k]);
               stream.push_back($urandom_range(0, 1) ? CH_H : CH_L);
            end
            7, 8: begin
               depth = $urandom_range(1, 7);
               for (int k = 0; k < depth; k++) stream.push_back(SYNC_PREFIX[k]);
               stream.push_back(rand_byte());
            end
            default: begin
               stream.push_back(CH_ESC);
               stream.push_back(rand_byte());
            end
         endcase
      end

      repeat (3) @(negedge clock);
      reset <= 1'b0;

      // Every third block of 40 bytes goes out back to back.
      foreach (stream[i]) begin
         gap = idle_cycles((i / 40) % 3 == 2);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         req_valid   <= 1'b1;
         req_in_byte <= stream[i];
         do @(posedge clock); while (req_stall);
         @(negedge clock);
      end
      req_valid <= 1'b0;

      while (outstanding != 0) @(negedge clock);
      repeat (20) @(negedge clock);

      if (mismatches == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
